@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property on the rising clock edge, switched off while reset is asserted.
`define BPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked property on the rising clock edge, also checked during reset.
`define BPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ src/bps_pkg.sv @@
// Types, codes and constants of the board power sequencer.
package bps_pkg;

    // Counter and timeout widths.
    localparam int unsigned CNT_W = 20;
    localparam logic [CNT_W-1:0] TIMEOUT_RESET = CNT_W'(40000);
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam int unsigned EV_W = 11;

    // Event flag bit positions.
    localparam int unsigned EV_WAKE          = 0;
    localparam int unsigned EV_LAUNCH_REL    = 1;
    localparam int unsigned EV_SHUT_PRESS    = 2;
    localparam int unsigned EV_ACTIVE_OFF    = 3;
    localparam int unsigned EV_ACTIVE_REL    = 4;
    localparam int unsigned EV_KEY_RELEASED  = 5;
    localparam int unsigned EV_KEY_PRESSED   = 6;
    localparam int unsigned EV_PASSIVE_OFF   = 7;
    localparam int unsigned EV_TIMEOUT       = 8;
    localparam int unsigned EV_PASSIVE_REL   = 9;
    localparam int unsigned EV_NO_SOURCE     = 10;

    // Sequencer phases.
    typedef enum logic [1:0] {
        PH_STANDBY  = 2'd0,
        PH_LAUNCH   = 2'd1,
        PH_WORKING  = 2'd2,
        PH_SHUTTING = 2'd3
    } phase_t;

    // Key source selection.
    typedef enum logic [1:0] {
        SRC_NONE    = 2'd0,
        SRC_ONBOARD = 2'd1,
        SRC_LAUNCH  = 2'd2,
        SRC_HY      = 2'd3
    } src_t;

    // Sampled key level, unknown when no source is selected.
    typedef enum logic [1:0] {
        LVL_RELEASED = 2'd0,
        LVL_PRESSED  = 2'd1,
        LVL_UNKNOWN  = 2'd2
    } lvl_t;

    // Input word: one tick of sampled levels.
    typedef struct packed {
        logic dc_in_present;
        logic onboard_key;
        logic launch_key;
        logic hy_on_key;
        logic hy_off_key;
        logic pc_running;
    } bps_in_t;

    // Result word.
    typedef struct packed {
        logic            board_power_on;
        logic            battery_on;
        logic            pc_enable_line;
        logic [1:0]      phase;
        logic [EV_W-1:0] event_flags;
    } bps_out_t;

endpackage

@@ src/bps_in_stage.sv @@
// Input register stage that captures one word per cycle from the input channel while its held word moves on.
module bps_in_stage import bps_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  bps_in_t s_data,
    input  logic    take,
    output logic    held_valid,
    output bps_in_t held_data
);

    logic    valid_reg;
    logic    valid_next;
    bps_in_t data_reg;

    // A new word enters when the stage is empty or its word moves on this cycle.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on every accepted word.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

@@ src/bps_engine.sv @@
// Sequencer state, per-tick decision logic and the result register.
module bps_engine import bps_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             held_valid,
    input  bps_in_t          held_data,
    output logic             take,
    input  logic [CNT_W-1:0] timeout_ticks,
    output logic             m_valid,
    input  logic             m_ready,
    output bps_out_t         m_data
);

    phase_t           phase_reg, phase_next;
    src_t             lsrc_reg, lsrc_next;
    src_t             ssrc_reg, ssrc_next;
    logic [CNT_W-1:0] elapsed_reg, elapsed_next;
    lvl_t             last_lvl_reg, last_lvl_next;
    logic             board_reg, board_next;
    logic             battery_reg, battery_next;
    logic             line_reg, line_next;
    logic             out_valid_reg, out_valid_next;
    bps_out_t         out_reg, out_next;

    src_t             wake_src;
    logic             wake;
    lvl_t             launch_lvl;
    lvl_t             shut_lvl;
    logic             pc_off;
    logic [CNT_W-1:0] cnt_inc;
    logic             timeup;
    logic [EV_W-1:0]  events;

    // Level of the key that plays the launch role for a source.
    function automatic lvl_t launch_level(input src_t src, input bps_in_t w);
        lvl_t r;
        case (src)
            SRC_ONBOARD: r = w.onboard_key ? LVL_PRESSED : LVL_RELEASED;
            SRC_LAUNCH:  r = w.launch_key ? LVL_PRESSED : LVL_RELEASED;
            SRC_HY:      r = w.hy_on_key ? LVL_PRESSED : LVL_RELEASED;
            default:     r = LVL_UNKNOWN;
        endcase
        return r;
    endfunction

    // Level of the key that plays the shutdown role for a source.
    function automatic lvl_t shutdown_level(input src_t src, input bps_in_t w);
        lvl_t r;
        case (src)
            SRC_ONBOARD: r = w.onboard_key ? LVL_PRESSED : LVL_RELEASED;
            SRC_LAUNCH:  r = w.launch_key ? LVL_PRESSED : LVL_RELEASED;
            SRC_HY:      r = w.hy_off_key ? LVL_PRESSED : LVL_RELEASED;
            default:     r = LVL_UNKNOWN;
        endcase
        return r;
    endfunction

    // The held word is processed when the result register is free or being drained.
    assign take = held_valid && (!out_valid_reg || m_ready);

    // Shared decode of the held word.
    assign launch_lvl = launch_level(lsrc_reg, held_data);
    assign shut_lvl   = shutdown_level(ssrc_reg, held_data);
    assign pc_off     = !held_data.pc_running;
    assign cnt_inc    = (elapsed_reg != COUNT_MAX) ? elapsed_reg + CNT_W'(1) : elapsed_reg;
    assign timeup     = (cnt_inc >= timeout_ticks);

    // Wake source priority: DC input with onboard key, launch key, remote on key.
    always_comb begin
        if (held_data.dc_in_present) begin
            wake_src = SRC_ONBOARD;
            wake     = held_data.onboard_key;
        end else if (held_data.launch_key) begin
            wake_src = SRC_LAUNCH;
            wake     = 1'b1;
        end else if (held_data.hy_on_key) begin
            wake_src = SRC_HY;
            wake     = 1'b1;
        end else begin
            wake_src = SRC_NONE;
            wake     = 1'b0;
        end
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_STANDBY: begin
                if (wake) begin
                    phase_next = PH_LAUNCH;
                end
            end
            PH_LAUNCH: begin
                if (launch_lvl == LVL_RELEASED) begin
                    phase_next = PH_WORKING;
                end
            end
            PH_WORKING: begin
                if (shut_lvl == LVL_PRESSED) begin
                    phase_next = PH_SHUTTING;
                end else if (pc_off && shut_lvl == LVL_RELEASED) begin
                    phase_next = PH_STANDBY;
                end
            end
            PH_SHUTTING: begin
                if ((timeup || pc_off) && shut_lvl == LVL_RELEASED) begin
                    phase_next = PH_STANDBY;
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Drive lines, sources, counter, key memory and event flags.
    always_comb begin
        lsrc_next     = lsrc_reg;
        ssrc_next     = ssrc_reg;
        elapsed_next  = elapsed_reg;
        last_lvl_next = last_lvl_reg;
        board_next    = board_reg;
        battery_next  = battery_reg;
        line_next     = line_reg;
        events        = '0;
        case (phase_reg)
            PH_STANDBY: begin
                lsrc_next = wake_src;
                ssrc_next = wake_src;
                if (wake_src == SRC_NONE) begin
                    board_next             = 1'b0;
                    battery_next           = 1'b0;
                    events[EV_NO_SOURCE]   = 1'b1;
                end
                if (wake) begin
                    events[EV_WAKE] = 1'b1;
                    board_next      = 1'b1;
                    battery_next    = 1'b1;
                    line_next       = 1'b0;
                end
            end
            PH_LAUNCH: begin
                if (launch_lvl == LVL_RELEASED) begin
                    events[EV_LAUNCH_REL] = 1'b1;
                    line_next             = 1'b1;
                end
            end
            PH_WORKING: begin
                if (shut_lvl == LVL_PRESSED) begin
                    events[EV_SHUT_PRESS] = 1'b1;
                    elapsed_next          = '0;
                end
                if (pc_off) begin
                    events[EV_ACTIVE_OFF] = 1'b1;
                    board_next            = 1'b0;
                    battery_next          = 1'b0;
                    if (shut_lvl == LVL_RELEASED) begin
                        events[EV_ACTIVE_REL] = 1'b1;
                    end
                end
            end
            PH_SHUTTING: begin
                if (shut_lvl == LVL_RELEASED) begin
                    events[EV_KEY_RELEASED] = (last_lvl_reg != LVL_RELEASED);
                    line_next               = 1'b1;
                end else if (shut_lvl == LVL_PRESSED) begin
                    events[EV_KEY_PRESSED] = (last_lvl_reg != LVL_PRESSED);
                    line_next              = 1'b0;
                end
                last_lvl_next = shut_lvl;
                elapsed_next  = cnt_inc;
                if (timeup || pc_off) begin
                    events[EV_PASSIVE_OFF] = pc_off;
                    events[EV_TIMEOUT]     = !pc_off;
                    board_next             = 1'b0;
                    battery_next           = 1'b0;
                    if (shut_lvl == LVL_RELEASED) begin
                        events[EV_PASSIVE_REL] = 1'b1;
                    end
                end
            end
            default: begin
                events = '0;
            end
        endcase
    end

    // Result word built from the state after this tick.
    always_comb begin
        out_next.board_power_on = board_next;
        out_next.battery_on     = battery_next;
        out_next.pc_enable_line = line_next;
        out_next.phase          = phase_next;
        out_next.event_flags    = events;
    end

    assign out_valid_next = take ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_STANDBY;
            lsrc_reg      <= SRC_NONE;
            ssrc_reg      <= SRC_NONE;
            elapsed_reg   <= '0;
            last_lvl_reg  <= LVL_UNKNOWN;
            board_reg     <= 1'b0;
            battery_reg   <= 1'b0;
            line_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                phase_reg    <= phase_next;
                lsrc_reg     <= lsrc_next;
                ssrc_reg     <= ssrc_next;
                elapsed_reg  <= elapsed_next;
                last_lvl_reg <= last_lvl_next;
                board_reg    <= board_next;
                battery_reg  <= battery_next;
                line_reg     <= line_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ src/board_power_sequencer.sv @@
// Top level of the board power sequencer: input stage, engine and timeout register.
//
//   Channel   Direction  Handshake           Word
//   s_        in         s_valid / s_ready   bps_in_t, one 1 ms tick of key levels
//   m_        out        m_valid / m_ready   bps_out_t, drive lines, phase, events
//   cfg_      in         cfg_we              shutdown timeout in ticks, 20 bits
//
// One word per cycle sustained while results are taken; each word yields exactly one result word.
// A word accepted on s_ enters the input register, then passes through the
// decision logic into the result register.
// Reset is synchronous, active low, and clears the phase, sources, counter and
// both valid flags; the timeout register returns to 40000 ticks.
// A stalled result holds the engine, and the input stage then fills and drops s_ready.
module board_power_sequencer import bps_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bps_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bps_out_t         m_data,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    logic [CNT_W-1:0] timeout_reg;
    logic             take;
    logic             held_valid;
    bps_in_t          held_data;

    // Shutdown timeout register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_wdata;
        end
    end

    bps_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    bps_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .held_valid    (held_valid),
        .held_data     (held_data),
        .take          (take),
        .timeout_ticks (timeout_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule

@@ src/bps_checker.sv @@
// Port-level checker for the board power sequencer and its bind statement.
`include "assert_macros.svh"

module bps_checker import bps_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input bps_out_t         m_data
);

    // A result word that is not taken stays on the port unchanged.
    `BPS_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result word dropped or changed while stalled")

    // No result word appears in the cycle after reset.
    `BPS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid right after reset")

    // A wake enters the launch phase with board and battery on and the line pulled low.
    `BPS_ASSERT(a_wake, aclk, aresetn, m_valid && m_data.event_flags[EV_WAKE] |-> m_data.phase == PH_LAUNCH && m_data.board_power_on && m_data.battery_on && !m_data.pc_enable_line, "wake without launch drive")

    // While the launch press is forwarded the board is powered and the line is low.
    `BPS_ASSERT(a_launch, aclk, aresetn, m_valid && m_data.phase == PH_LAUNCH |-> m_data.board_power_on && m_data.battery_on && !m_data.pc_enable_line, "launch phase with wrong drive")

    // Without a wake source the board and battery are off and the block stays in standby.
    `BPS_ASSERT(a_no_source, aclk, aresetn, m_valid && m_data.event_flags[EV_NO_SOURCE] |-> !m_data.board_power_on && !m_data.battery_on && m_data.phase == PH_STANDBY, "power left on without wake source")

endmodule

bind board_power_sequencer bps_checker u_bps_checker (.*);
